>>> src/double_ended_queue_unit_macros.svh
// assertion helpers for the deque unit, sampled on clk and disabled while rst is high
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int ELEM_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [REQ_W-1:0]         req_t;
  typedef logic [STAT_W-1:0]        stat_t;

  localparam elem_t INT_MAX = 32'sh7FFF_FFFF;

  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_QUERY      = 3'd4;

  localparam stat_t STAT_DONE      = 2'd0;
  localparam stat_t STAT_POP_EMPTY = 2'd1;
  localparam stat_t STAT_PUSH_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the request
    logic exec;  // update pointers, count and store
    logic read;  // fetch front and back entries
  } deq_cmd_t;

endpackage

`default_nettype wire

>>> src/deq_ctrl.sv
`default_nettype none

module deq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  output logic                 done,
  output deq_pkg::deq_cmd_t    cmd
);
  import deq_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == ST_EXEC) || (state == ST_READ);
  assign accept = start && !busy;
  assign done   = (state == ST_RESP);

  assign cmd.load = accept;
  assign cmd.exec = (state == ST_EXEC);
  assign cmd.read = (state == ST_READ);

  always_comb begin
    case (state)
      ST_IDLE: begin
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        // a new item may enter while the result is shown
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/deq_dpath.sv
`default_nettype none

module deq_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire deq_pkg::deq_cmd_t            cmd,
  input  wire deq_pkg::req_t                req_type,
  input  wire deq_pkg::elem_t               push_value,
  output deq_pkg::elem_t                    front_value,
  output deq_pkg::elem_t                    back_value,
  output logic [$clog2(DEPTH+1)-1:0]        fill_count,
  output logic                              is_empty,
  output deq_pkg::stat_t                    status
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  localparam logic [IW-1:0] LAST_POS = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] WRAP     = SW'(DEPTH);

  elem_t mem [DEPTH];

  req_t  req_q;
  elem_t val_q;
  elem_t front_q;
  elem_t back_q;

  logic [IW-1:0] first_index;
  logic [IW-1:0] first_index_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  stat_t         status_q;
  stat_t         status_next;

  logic          full;
  logic          empty;
  logic [IW-1:0] first_dec;
  logic [IW-1:0] first_inc;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail_pos;
  logic [SW-1:0] back_sum;
  logic [IW-1:0] back_pos;
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);

  // ring arithmetic, works for any depth
  assign first_dec = (first_index == '0) ? LAST_POS : first_index - 1'b1;
  assign first_inc = (first_index == LAST_POS) ? '0 : first_index + 1'b1;

  assign tail_sum = {1'b0, first_index} + SW'(count);
  assign tail_pos = (tail_sum >= WRAP) ? IW'(tail_sum - WRAP) : IW'(tail_sum);

  assign back_sum = {1'b0, first_index} + SW'(count) - 1'b1;
  assign back_pos = (back_sum >= WRAP) ? IW'(back_sum - WRAP) : IW'(back_sum);

  always_comb begin
    first_index_next = first_index;
    count_next       = count;
    status_next      = STAT_DONE;
    wr_en            = 1'b0;
    wr_addr          = tail_pos;
    case (req_q)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_next = STAT_PUSH_FULL;
        end else begin
          first_index_next = first_dec;
          wr_en            = 1'b1;
          wr_addr          = first_dec;
          count_next       = count + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_next = STAT_PUSH_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_next = STAT_POP_EMPTY;
        end else begin
          first_index_next = first_inc;
          count_next       = count - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_next = STAT_POP_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      REQ_QUERY: begin
        status_next = STAT_DONE;
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      val_q <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_index <= '0;
      count       <= '0;
      status_q    <= STAT_DONE;
    end else if (cmd.exec) begin
      first_index <= first_index_next;
      count       <= count_next;
      status_q    <= status_next;
    end
  end

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd.read) begin
      front_q <= mem[first_index];
      back_q  <= mem[back_pos];
    end
  end

  assign front_value = empty ? INT_MAX : front_q;
  assign back_value  = empty ? INT_MAX : back_q;
  assign fill_count  = count;
  assign is_empty    = empty;
  assign status      = status_q;

endmodule

`default_nettype wire

>>> src/double_ended_queue_unit.sv
// double-ended queue of signed 32-bit values held in a ring store of DEPTH entries
//
// request channel: an item (req_type, push_value) is taken at a rising edge with
//   start high and busy low; req_type 0 push front, 1 push back, 2 pop front,
//   3 pop back, anything else query only
// result channel: done is high for exactly one cycle and carries front_value,
//   back_value (both 2147483647 when empty), fill_count, is_empty and status
//   (0 done, 1 pop on empty ignored, 2 push on full rejected)
// path: an accepted item passes the exec state and then the read state, and its
//   result is shown in the resp state; a new item may be started in the cycle
//   that shows the previous result, but not while busy. the store sets this pace:
//   the item writes its entry in the exec state, and front and back are read
//   from it with registered read data in the read state that follows
// reset: rst is synchronous; it empties the deque and returns the controller to
//   idle. stored entries are not cleared, only held entries are ever shown
// the receiver has no stall: each result is shown once and must be taken then
`include "double_ended_queue_unit_macros.svh"
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire deq_pkg::req_t            req_type,
  input  wire deq_pkg::elem_t           push_value,
  // result channel
  output logic                          done,
  output deq_pkg::elem_t                front_value,
  output deq_pkg::elem_t                back_value,
  output logic [$clog2(DEPTH+1)-1:0]    fill_count,
  output logic                          is_empty,
  output deq_pkg::stat_t                status
);
  import deq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  deq_cmd_t cmd;

  // sequencer: idle, exec (pointer and store update), read, resp
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // request registers, ring pointers, count and the element store
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .push_value  (push_value),
    .front_value (front_value),
    .back_value  (back_value),
    .fill_count  (fill_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  // an accepted item keeps the block busy for its update cycle
  `DEQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && cmd.exec, "accepted item did not start")
  // the count never passes the store depth
  `DEQ_ASSERT_NOW(a_count_bound, done, fill_count <= CW'(DEPTH), "fill count beyond depth")
  // a rejected push only happens on a full store
  `DEQ_ASSERT_NOW(a_full_reject, done && (status == STAT_PUSH_FULL), fill_count == CW'(DEPTH), "push rejected while not full")
  // an empty deque shows the empty marker on both ends
  `DEQ_ASSERT_NOW(a_empty_marker, done && is_empty, (front_value == INT_MAX) && (back_value == INT_MAX), "empty deque shows stale values")

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // request codes with no meaning of their own, they behave as a query
  localparam req_t REQ_SPARE_5 = 3'd5;
  localparam req_t REQ_SPARE_6 = 3'd6;
  localparam req_t REQ_SPARE_7 = 3'd7;

  localparam elem_t INT_MIN = 32'sh8000_0000;

  // cycles with neither an accepted item nor a result before giving up
  localparam int STALL_LIMIT = 2000;
  // settle time after the last result
  localparam int TAIL_CYCLES = 10;

  // what the block reports after each item
  typedef struct {
    elem_t            front;
    elem_t            back;
    logic [CNT_W-1:0] count;
    logic             empty;
    stat_t            stat;
  } deque_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  req_t                 req_type = REQ_QUERY;
  elem_t                push_value = '0;
  logic                 busy;
  logic                 done;
  elem_t                front_value;
  elem_t                back_value;
  logic [CNT_W-1:0]     fill_count;
  logic                 is_empty;
  stat_t                status;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .push_value  (push_value),
    .done        (done),
    .front_value (front_value),
    .back_value  (back_value),
    .fill_count  (fill_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  always #10 clk = ~clk;

  // shadow deque: ring of DEPTH entries, head position and number held
  elem_t       ring_store [DEPTH];
  int          head_pos = 0;
  int          held = 0;

  // views still owed by the block, oldest first
  deque_view_t expected_views [$];

  int          error_count = 0;
  int          stall_cycles = 0;
  // when set, items are sent back to back with no idle cycles
  bit          idle_off = 1'b0;

  // apply one request to the shadow deque and return the view it should give
  function automatic deque_view_t apply_request(input req_t req, input elem_t val);
    deque_view_t view;
    view.stat = STAT_DONE;
    case (req)
      REQ_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          view.stat = STAT_PUSH_FULL;
        end else begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          ring_store[head_pos] = val;
          held++;
        end
      end
      REQ_PUSH_BACK: begin
        if (held >= DEPTH) begin
          view.stat = STAT_PUSH_FULL;
        end else begin
          ring_store[(head_pos + held) % DEPTH] = val;
          held++;
        end
      end
      REQ_POP_FRONT: begin
        if (held == 0) begin
          view.stat = STAT_POP_EMPTY;
        end else begin
          head_pos = (head_pos + 1) % DEPTH;
          held--;
        end
      end
      REQ_POP_BACK: begin
        if (held == 0) begin
          view.stat = STAT_POP_EMPTY;
        end else begin
          held--;
        end
      end
      // query and the spare codes leave the deque alone
      default: ;
    endcase
    if (held == 0) begin
      view.front = INT_MAX;
      view.back  = INT_MAX;
    end else begin
      view.front = ring_store[head_pos];
      view.back  = ring_store[(head_pos + held - 1) % DEPTH];
    end
    view.count = held[CNT_W-1:0];
    view.empty = (held == 0);
    return view;
  endfunction

  // idle cycles before the next item: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // payload with extra weight on the extremes
  function automatic elem_t pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return INT_MAX;
    if (roll < 16) return INT_MIN;
    if (roll < 20) return '0;
    if (roll < 24) return -1;
    return elem_t'($urandom());
  endfunction

  // drive one item at the falling edge and hold it until the block takes it
  task automatic send_item(input req_t req, input elem_t val);
    int          gap;
    deque_view_t view;
    gap = idle_off ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      = 1'b1;
    req_type   = req;
    push_value = val;
    // taken at the first rising edge with busy low
    do @(posedge clk); while (busy !== 1'b0);
    view = apply_request(req, val);
    expected_views.push_back(view);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
      error_count++;
    end
  endtask

  // each result is shown for one cycle and must be taken at that edge
  always @(posedge clk) begin : check_results
    deque_view_t want;
    if (!rst && done === 1'b1) begin
      if (expected_views.size() == 0) begin
        $display("%0t: result with no item outstanding, front %h back %h count %0d",
                 $time, front_value, back_value, fill_count);
        error_count++;
      end else begin
        want = expected_views.pop_front();
        check_field("front_value", 64'(want.front), 64'(front_value));
        check_field("back_value", 64'(want.back), 64'(back_value));
        check_field("fill_count", 64'(want.count), 64'(fill_count));
        check_field("is_empty", 64'(want.empty), 64'(is_empty));
        check_field("status", 64'(want.stat), 64'(status));
      end
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // requests on an empty deque: query, both pops ignored, spare codes
  task automatic test_empty_requests();
    send_item(REQ_QUERY, pick_value());
    send_item(REQ_POP_FRONT, pick_value());
    send_item(REQ_POP_BACK, pick_value());
    send_item(REQ_SPARE_5, pick_value());
    send_item(REQ_SPARE_6, pick_value());
    send_item(REQ_SPARE_7, pick_value());
  endtask

  // fill from both ends with the extremes first, then push on full at both ends
  task automatic test_fill_to_full();
    send_item(REQ_PUSH_FRONT, INT_MIN);
    send_item(REQ_PUSH_BACK, INT_MAX);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_item(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    end
    send_item(REQ_PUSH_FRONT, -1);
    send_item(REQ_PUSH_BACK, '0);
  endtask

  // take one off each end of the full deque
  task automatic test_pop_both_ends();
    send_item(REQ_POP_FRONT, '0);
    send_item(REQ_POP_BACK, '0);
  endtask

  // bursts that lean toward filling, draining or neither, so the ring wraps
  // many times and both the full and the empty edge are hit often
  task automatic test_random_traffic(input int n_items);
    int   left;
    int   burst;
    int   push_pct;
    int   roll;
    req_t req;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      // about a quarter of the bursts run with no idle cycles at all
      idle_off = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst && left > 0; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          case ($urandom_range(0, 3))
            0:       req = REQ_QUERY;
            1:       req = REQ_SPARE_5;
            2:       req = REQ_SPARE_6;
            default: req = REQ_SPARE_7;
          endcase
        end else if (roll < 3 + push_pct) begin
          req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else begin
          req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
        send_item(req, pick_value());
        left--;
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_requests();
    test_fill_to_full();
    test_pop_both_ends();
    test_random_traffic(1800);

    @(negedge clk);
    start = 1'b0;
    // wait for every outstanding result, then a little longer for strays
    while (expected_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
